// File: sv/htb_pkg.sv
// Package for the Huffman tree builder: sizes, request codes and memory entry types.
// Depends on nothing; the interfaces and the top level import it.
package htb_pkg;

  localparam int unsigned NumSymbols = 256;
  localparam int unsigned IdxW       = $clog2(NumSymbols);
  localparam int unsigned CountW     = 24;
  localparam int unsigned WeightW    = 32;
  localparam int unsigned ChildW     = 9;

  // Request codes carried in req_type.
  localparam logic [1:0] ReqLoad  = 2'd0;
  localparam logic [1:0] ReqBuild = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  localparam logic [CountW-1:0]  LeafMax       = 24'hFFFFFF;
  localparam logic [WeightW-1:0] WeightInitMin = 32'hFFFFFFFE;
  localparam logic [WeightW-1:0] WeightInitSec = 32'hFFFFFFFF;

  // One slot of the working list: weight and child reference.
  typedef struct packed {
    logic [WeightW-1:0]       weight;
    logic signed [ChildW-1:0] child;
  } work_entry_t;

  // One tree node: summed weight and both children.
  typedef struct packed {
    logic [WeightW-1:0]       weight;
    logic signed [ChildW-1:0] left;
    logic signed [ChildW-1:0] right;
  } node_entry_t;

endpackage

// File: sv/htb_if.sv
// Request and response channel interfaces of the Huffman tree builder.
// Depends on htb_pkg for the field widths.
interface htb_req_if;
  import htb_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [IdxW-1:0]   item_index;
  logic [CountW-1:0] base_count;

  modport source (output valid, output req_type, output item_index, output base_count,
                  input ready);
  modport sink (input valid, input req_type, input item_index, input base_count,
                output ready);
endinterface

interface htb_rsp_if;
  import htb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     tree_ready;
  logic [WeightW-1:0]       node_weight;
  logic signed [ChildW-1:0] left_child;
  logic signed [ChildW-1:0] right_child;

  modport source (output valid, output tree_ready, output node_weight, output left_child,
                  output right_child, input ready);
  modport sink (input valid, input tree_ready, input node_weight, input left_child,
                input right_child, output ready);
endinterface

// File: sv/huffman_tree_builder_unit.sv
// Huffman tree builder over 256 symbols: leaf, working-list and node memories.
// A load or an unknown request gives its result in the cycle after acceptance, a node read
// passes the node memory read register and then the result register, and a build copies the
// leaves, for each of the 255 merges scans the list, drains and fills two slots, then the root.
// One request is in work at a time; the scan over the working-list read port sets the rate.
// Reset (rst_ni, asynchronous, active low) clears control state and the built flag only.
// Depends on htb_pkg and on the interfaces in htb_if.sv.
module huffman_tree_builder_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  htb_req_if.sink   req_i,
  htb_rsp_if.source rsp_o
);
  import htb_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NREAD  = 4'd1;  // node memory read in flight
  localparam logic [3:0] S_COPY   = 4'd2;  // leaves into the working list
  localparam logic [3:0] S_CDRAIN = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;  // search for the two smallest weights
  localparam logic [3:0] S_SDRAIN = 4'd5;
  localparam logic [3:0] S_WLO    = 4'd6;  // merged node into the lower slot
  localparam logic [3:0] S_WHI    = 4'd7;  // last slot into the higher slot
  localparam logic [3:0] S_ROOT   = 4'd8;  // copy of the final node to node 0

  localparam int unsigned SizeW = IdxW + 1;

  // Memories. Each has one write port and one registered read port.
  logic [CountW-1:0] leaf_mem [NumSymbols];
  work_entry_t       work_mem [NumSymbols];
  node_entry_t       node_mem [NumSymbols];

  logic [CountW-1:0] leaf_rdata_q;
  work_entry_t       work_rdata_q;
  node_entry_t       node_rdata_q;

  logic              leaf_we;
  logic [CountW-1:0] leaf_wdata;
  logic              work_we, work_re;
  logic [IdxW-1:0]   work_waddr;
  work_entry_t       work_wdata;
  logic              node_we, node_re;
  logic [IdxW-1:0]   node_waddr;
  node_entry_t       node_wdata;

  // Control registers.
  logic [3:0]       state_q, state_d;
  logic             built_q, built_d;
  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [IdxW-1:0]  nn_q, nn_d;
  logic             pipe_v_q, pipe_v_d;

  // Datapath registers.
  logic [IdxW-1:0]          pipe_idx_q, pipe_idx_d;
  logic [WeightW-1:0]       mw_q, mw_d, sw_q, sw_d;
  logic [IdxW-1:0]          mi_q, mi_d, si_q, si_d;
  logic signed [ChildW-1:0] mref_q, mref_d, sref_q, sref_d;
  work_entry_t              last_q, last_d;
  logic                     out_tr_q, out_tr_d;
  logic [WeightW-1:0]       out_w_q, out_w_d;
  logic signed [ChildW-1:0] out_l_q, out_l_d, out_r_q, out_r_d;

  logic               accept;
  logic [IdxW-1:0]    last_idx;
  logic [IdxW-1:0]    lo_idx, hi_idx;
  logic [WeightW-1:0] merge_sum;

  // A new request is taken only when the sequencer is idle and the result register is free
  // or being emptied in this cycle.
  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.tree_ready  = out_tr_q;
  assign rsp_o.node_weight = out_w_q;
  assign rsp_o.left_child  = out_l_q;
  assign rsp_o.right_child = out_r_q;

  // The slot that holds the last live entry of the working list.
  assign last_idx  = IdxW'(size_q - SizeW'(1));
  assign lo_idx    = (mi_q < si_q) ? mi_q : si_q;
  assign hi_idx    = (mi_q < si_q) ? si_q : mi_q;
  assign merge_sum = mw_q + sw_q;

  always_comb begin
    state_d     = state_q;
    built_d     = built_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ptr_d       = ptr_q;
    size_d      = size_q;
    nn_d        = nn_q;
    pipe_v_d    = 1'b0;
    pipe_idx_d  = pipe_idx_q;
    mw_d        = mw_q;
    sw_d        = sw_q;
    mi_d        = mi_q;
    si_d        = si_q;
    mref_d      = mref_q;
    sref_d      = sref_q;
    last_d      = last_q;
    out_tr_d    = out_tr_q;
    out_w_d     = out_w_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;

    leaf_we    = 1'b0;
    leaf_wdata = (req_i.base_count == LeafMax) ? LeafMax : req_i.base_count + CountW'(1);
    work_we    = 1'b0;
    work_re    = 1'b0;
    work_waddr = pipe_idx_q;
    work_wdata = '{weight: WeightW'(leaf_rdata_q), child: ~{1'b0, pipe_idx_q}};
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_waddr = nn_q;
    node_wdata = '{weight: merge_sum, left: mref_q, right: sref_q};

    // The scan compares each returned slot against the running minimum and second minimum.
    // A new minimum pushes the old one down to second place.
    if (pipe_v_q && (state_q == S_SCAN || state_q == S_SDRAIN)) begin
      if (work_rdata_q.weight < mw_q) begin
        sw_d   = mw_q;
        si_d   = mi_q;
        sref_d = mref_q;
        mw_d   = work_rdata_q.weight;
        mi_d   = pipe_idx_q;
        mref_d = work_rdata_q.child;
      end else if (work_rdata_q.weight < sw_q) begin
        sw_d   = work_rdata_q.weight;
        si_d   = pipe_idx_q;
        sref_d = work_rdata_q.child;
      end
      if (pipe_idx_q == last_idx) begin
        last_d = work_rdata_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            ReqLoad: begin
              leaf_we     = 1'b1;
              built_d     = 1'b0;
              out_valid_d = 1'b1;
              out_tr_d    = 1'b0;
              out_w_d     = '0;
              out_l_d     = '0;
              out_r_d     = '0;
            end
            ReqBuild: begin
              state_d = S_COPY;
              ptr_d   = '0;
            end
            ReqRead: begin
              node_re = 1'b1;
              state_d = S_NREAD;
            end
            default: begin
              out_valid_d = 1'b1;
              out_tr_d    = built_q;
              out_w_d     = '0;
              out_l_d     = '0;
              out_r_d     = '0;
            end
          endcase
        end
      end
      S_NREAD: begin
        out_valid_d = 1'b1;
        out_tr_d    = built_q;
        out_w_d     = node_rdata_q.weight;
        out_l_d     = node_rdata_q.left;
        out_r_d     = node_rdata_q.right;
        state_d     = S_IDLE;
      end
      S_COPY, S_CDRAIN: begin
        // Leaf reads go out one per cycle; each returns in the next cycle and is written as a
        // leaf reference into the same slot.
        work_we = pipe_v_q;
        if (state_q == S_COPY) begin
          pipe_v_d   = 1'b1;
          pipe_idx_d = ptr_q;
          ptr_d      = ptr_q + IdxW'(1);
          if (ptr_q == IdxW'(NumSymbols - 1)) begin
            state_d = S_CDRAIN;
          end
        end else begin
          state_d = S_SCAN;
          ptr_d   = '0;
          size_d  = SizeW'(NumSymbols);
          nn_d    = IdxW'(1);
          mw_d    = WeightInitMin;
          sw_d    = WeightInitSec;
          mi_d    = '0;
          si_d    = '0;
          mref_d  = '0;
          sref_d  = '0;
        end
      end
      S_SCAN: begin
        work_re    = 1'b1;
        pipe_v_d   = 1'b1;
        pipe_idx_d = ptr_q;
        if (ptr_q == last_idx) begin
          ptr_d   = '0;
          state_d = S_SDRAIN;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      S_SDRAIN: begin
        state_d = S_WLO;
      end
      S_WLO: begin
        work_we    = 1'b1;
        work_waddr = lo_idx;
        work_wdata = '{weight: merge_sum, child: {1'b0, nn_q}};
        node_we    = 1'b1;
        state_d    = S_WHI;
      end
      S_WHI: begin
        // The last slot fills the hole, unless the hole is the last slot itself.
        work_we    = (hi_idx != last_idx);
        work_waddr = hi_idx;
        work_wdata = last_q;
        size_d     = size_q - SizeW'(1);
        nn_d       = nn_q + IdxW'(1);
        if (size_q == SizeW'(2)) begin
          state_d = S_ROOT;
        end else begin
          state_d = S_SCAN;
          mw_d    = WeightInitMin;
          sw_d    = WeightInitSec;
          mi_d    = '0;
          si_d    = '0;
          mref_d  = '0;
          sref_d  = '0;
        end
      end
      S_ROOT: begin
        // The merge registers still hold the final merge, so the root is rewritten as node 0.
        node_we     = 1'b1;
        node_waddr  = '0;
        built_d     = 1'b1;
        out_valid_d = 1'b1;
        out_tr_d    = 1'b1;
        out_w_d     = '0;
        out_l_d     = '0;
        out_r_d     = '0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      size_q      <= '0;
      nn_q        <= '0;
      pipe_v_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      size_q      <= size_d;
      nn_q        <= nn_d;
      pipe_v_q    <= pipe_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    mw_q       <= mw_d;
    sw_q       <= sw_d;
    mi_q       <= mi_d;
    si_q       <= si_d;
    mref_q     <= mref_d;
    sref_q     <= sref_d;
    last_q     <= last_d;
    out_tr_q   <= out_tr_d;
    out_w_q    <= out_w_d;
    out_l_q    <= out_l_d;
    out_r_q    <= out_r_d;
  end

  // Leaf memory: written by loads, read in order during the copy.
  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[req_i.item_index] <= leaf_wdata;
    end
    leaf_rdata_q <= leaf_mem[ptr_q];
  end

  // Working list. Reads happen only in the scan and writes only outside it, so no slot is
  // read and written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    if (work_re) begin
      work_rdata_q <= work_mem[ptr_q];
    end
  end

  // Node store.
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rdata_q <= node_mem[req_i.item_index];
    end
  end

`ifndef SYNTHESIS
  // A merge always takes two distinct slots.
  a_distinct_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WLO) |-> (mi_q != si_q))
    else $error("merge picked the same slot twice");

  // The scan only runs while at least two entries are live.
  a_scan_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (size_q >= SizeW'(2)) && (size_q <= SizeW'(NumSymbols)))
    else $error("scan with an out-of-range list size");

  // Merged weights never wrap.
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WLO) |-> (merge_sum >= mw_q))
    else $error("merged weight overflowed");

  // A load gives its result in the next cycle and marks the tree stale.
  a_load_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type == ReqLoad) |=> (rsp_o.valid && !rsp_o.tree_ready && !built_q))
    else $error("load response missing or tree still marked ready");

  // The end of a build leaves the tree marked ready.
  a_build_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT) |=> (built_q && rsp_o.valid && rsp_o.tree_ready))
    else $error("build finished without a ready tree");
`endif

endmodule
